[sv/ksc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register indexes and reset constants for the knob setpoint controller.
// No dependencies; used by ksc_step and knob_setpoint_controller.
package ksc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NOW_W           = 32;
    localparam int CNT_IN_W        = 16;
    localparam int VAL_W           = 13;
    localparam int SUM_W           = VAL_W + 2;
    localparam int STEP_W          = 10;
    localparam int PPD_W           = 7;
    localparam int LONG_W          = 16;
    localparam int DEB_W           = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int S_TDATA_W       = 56;
    localparam int M_TDATA_W       = 40;

    localparam logic [VAL_W-1:0] CURR_STEP_MA = 13'd100;
    localparam logic [VAL_W-1:0] VOLT_RESET   = 13'd100;
    localparam logic [VAL_W-1:0] CURR_RESET   = 13'd0;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TIMING = 2'd1,
        PH_WAIT   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE    = 3'd0,
        REG_LONG_PRESS  = 3'd1,
        REG_PPD         = 3'd2,
        REG_VOLT_MIN    = 3'd3,
        REG_VOLT_MAX    = 3'd4,
        REG_CURR_MAX    = 3'd5,
        REG_VOLT_FINE   = 3'd6,
        REG_VOLT_COARSE = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic [LONG_W-1:0] long_press_ms;
        logic [PPD_W-1:0]  pulses_per_detent;
        logic [VAL_W-1:0]  volt_min;
        logic [VAL_W-1:0]  volt_max;
        logic [VAL_W-1:0]  curr_max;
        logic [STEP_W-1:0] volt_fine_step;
        logic [STEP_W-1:0] volt_coarse_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_ms:       8'd20,
        long_press_ms:     16'd500,
        pulses_per_detent: 7'd4,
        volt_min:          13'd100,
        volt_max:          13'd4400,
        curr_max:          13'd3500,
        volt_fine_step:    10'd10,
        volt_coarse_step:  10'd100
    };

    typedef struct packed {
        phase_t           phase;
        logic [NOW_W-1:0] press_start;
        logic             adjust_current;
        logic             coarse_step;
        logic [VAL_W-1:0] volt_value;
        logic [VAL_W-1:0] curr_value;
    } ctl_state_t;

    // Packed from the top: lowest member lands in the lowest bits.
    typedef struct packed {
        logic             setpoint_changed;
        logic             coarse_mode;
        logic             current_mode;
        logic [VAL_W-1:0] curr_setpoint;
        logic [VAL_W-1:0] volt_setpoint;
        logic [1:0]       direction;
        event_t           button_event;
    } result_t;

endpackage

[sv/ksc_step.sv]
`timescale 1ns / 1ps
// Single-scan logic: press machine, detent extraction and clamped setpoint update.
// Depends on ksc_pkg.
module ksc_step #(
    parameter int COUNT_WIDTH = ksc_pkg::COUNT_WIDTH_DEF
) (
    input  ksc_pkg::cfg_t                    cfg,
    input  ksc_pkg::ctl_state_t              st,
    input  logic [COUNT_WIDTH-1:0]           last_count,
    input  logic [ksc_pkg::NOW_W-1:0]        now_ms,
    input  logic                             button_level,
    input  logic [ksc_pkg::CNT_IN_W-1:0]     encoder_count,
    output ksc_pkg::ctl_state_t              st_next,
    output logic [COUNT_WIDTH-1:0]           last_count_next,
    output ksc_pkg::result_t                 res
);

    logic [ksc_pkg::NOW_W-1:0]       held;
    ksc_pkg::event_t                 ev;
    ksc_pkg::ctl_state_t             btn;
    logic [COUNT_WIDTH-1:0]          cnt;
    logic [COUNT_WIDTH-1:0]          diff;
    logic [COUNT_WIDTH-1:0]          neg_diff;
    logic [COUNT_WIDTH-1:0]          ppd_w;
    logic [ksc_pkg::PPD_W-1:0]       ppd;
    logic                            up;
    logic                            down;
    logic [ksc_pkg::STEP_W-1:0]      vstep;
    logic signed [ksc_pkg::SUM_W-1:0] volt_s;
    logic signed [ksc_pkg::SUM_W-1:0] vstep_s;
    logic signed [ksc_pkg::SUM_W-1:0] vmin_s;
    logic signed [ksc_pkg::SUM_W-1:0] vmax_s;
    logic signed [ksc_pkg::SUM_W-1:0] v_sum;
    logic signed [ksc_pkg::SUM_W-1:0] v_lo;
    logic signed [ksc_pkg::SUM_W-1:0] v_cl;
    logic signed [ksc_pkg::SUM_W-1:0] curr_s;
    logic signed [ksc_pkg::SUM_W-1:0] cstep_s;
    logic signed [ksc_pkg::SUM_W-1:0] cmax_s;
    logic signed [ksc_pkg::SUM_W-1:0] c_sum;
    logic signed [ksc_pkg::SUM_W-1:0] c_lo;
    logic signed [ksc_pkg::SUM_W-1:0] c_cl;

    assign held = now_ms - st.press_start;

    always_comb
    begin
        btn = st;
        ev  = ksc_pkg::EV_NONE;
        unique case (st.phase)
            ksc_pkg::PH_TIMING:
            begin
                if (button_level)
                begin
                    if (held > {24'd0, cfg.debounce_ms} && held < {16'd0, cfg.long_press_ms})
                    begin
                        btn.adjust_current = ~st.adjust_current;
                        ev = ksc_pkg::EV_SHORT;
                    end
                    btn.phase = ksc_pkg::PH_IDLE;
                end
                else if (held >= {16'd0, cfg.long_press_ms})
                begin
                    btn.coarse_step = ~st.coarse_step;
                    ev = ksc_pkg::EV_LONG;
                    btn.phase = ksc_pkg::PH_WAIT;
                end
            end
            ksc_pkg::PH_WAIT:
            begin
                if (button_level)
                begin
                    btn.phase = ksc_pkg::PH_IDLE;
                end
            end
            default:
            begin
                if (!button_level)
                begin
                    btn.press_start = now_ms;
                    btn.phase = ksc_pkg::PH_TIMING;
                end
            end
        endcase
    end

    assign cnt      = COUNT_WIDTH'(encoder_count);
    assign diff     = cnt - last_count;
    assign neg_diff = -diff;
    assign ppd      = (cfg.pulses_per_detent == '0) ? ksc_pkg::PPD_W'(1) : cfg.pulses_per_detent;
    assign ppd_w    = COUNT_WIDTH'(ppd);
    assign up       = !diff[COUNT_WIDTH-1] && (diff >= ppd_w);
    assign down     = diff[COUNT_WIDTH-1] && (neg_diff >= ppd_w);

    assign last_count_next = up ? last_count + ppd_w : (down ? last_count - ppd_w : last_count);

    assign vstep   = btn.coarse_step ? cfg.volt_coarse_step : cfg.volt_fine_step;
    assign volt_s  = $signed({2'b00, btn.volt_value});
    assign vstep_s = $signed({5'd0, vstep});
    assign vmin_s  = $signed({2'b00, cfg.volt_min});
    assign vmax_s  = $signed({2'b00, cfg.volt_max});
    assign v_sum   = down ? volt_s - vstep_s : volt_s + vstep_s;
    assign v_lo    = (v_sum < vmin_s) ? vmin_s : v_sum;
    assign v_cl    = (v_lo > vmax_s) ? vmax_s : v_lo;

    assign curr_s  = $signed({2'b00, btn.curr_value});
    assign cstep_s = $signed({2'b00, ksc_pkg::CURR_STEP_MA});
    assign cmax_s  = $signed({2'b00, cfg.curr_max});
    assign c_sum   = down ? curr_s - cstep_s : curr_s + cstep_s;
    assign c_lo    = c_sum[ksc_pkg::SUM_W-1] ? '0 : c_sum;
    assign c_cl    = (c_lo > cmax_s) ? cmax_s : c_lo;

    always_comb
    begin
        st_next = btn;
        if ((up || down) && btn.adjust_current)
        begin
            st_next.curr_value = c_cl[ksc_pkg::VAL_W-1:0];
        end
        else if (up || down)
        begin
            st_next.volt_value = v_cl[ksc_pkg::VAL_W-1:0];
        end
    end

    always_comb
    begin
        res.button_event     = ev;
        res.direction        = up ? ksc_pkg::DIR_UP : (down ? ksc_pkg::DIR_DOWN : ksc_pkg::DIR_NONE);
        res.volt_setpoint    = st_next.volt_value;
        res.curr_setpoint    = st_next.curr_value;
        res.current_mode     = st_next.adjust_current;
        res.coarse_mode      = st_next.coarse_step;
        res.setpoint_changed = up || down;
    end

endmodule

[sv/knob_setpoint_controller.sv]
`timescale 1ns / 1ps
// Knob setpoint controller top level: input register, scan logic, result register.
// Input register holds a scan; its result is registered once the output can accept it.
// Throughput: one scan per cycle unless the output stalls; ksc_step is combinational.
// Reset: asynchronous, clears press state, counter history, modes and restores
// setpoints (1.00 V, 0 A) and all configuration registers to their defaults.
// Depends on ksc_pkg and ksc_step.
module knob_setpoint_controller #(
    parameter int COUNT_WIDTH = ksc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // now_ms[31:0], button_level[32], encoder_count[48:33], zero fill
    input  logic [ksc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // button_event[1:0], direction[3:2], volt_setpoint[16:4], curr_setpoint[29:17],
    // current_mode[30], coarse_mode[31], setpoint_changed[32], zero fill
    output logic [ksc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ksc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ksc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                              in_valid_reg;
    logic [ksc_pkg::NOW_W-1:0]         now_reg;
    logic                              level_reg;
    logic [ksc_pkg::CNT_IN_W-1:0]      count_reg;
    logic                              out_valid_reg;
    ksc_pkg::result_t                  out_reg;
    ksc_pkg::cfg_t                     cfg_reg;
    ksc_pkg::cfg_t                     cfg_next;
    ksc_pkg::ctl_state_t               st_reg;
    ksc_pkg::ctl_state_t               st_next;
    logic [COUNT_WIDTH-1:0]            last_count_reg;
    logic [COUNT_WIDTH-1:0]            last_count_next;
    ksc_pkg::result_t                  res_next;
    logic                              out_ready;
    logic                              adv;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign adv           = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg};
    assign cfg_ready     = 1'b1;

    ksc_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .cfg             (cfg_reg),
        .st              (st_reg),
        .last_count      (last_count_reg),
        .now_ms          (now_reg),
        .button_level    (level_reg),
        .encoder_count   (count_reg),
        .st_next         (st_next),
        .last_count_next (last_count_next),
        .res             (res_next)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (ksc_pkg::reg_index_t'(cfg_index))
                ksc_pkg::REG_DEBOUNCE:    cfg_next.debounce_ms       = cfg_data[ksc_pkg::DEB_W-1:0];
                ksc_pkg::REG_LONG_PRESS:  cfg_next.long_press_ms     = cfg_data[ksc_pkg::LONG_W-1:0];
                ksc_pkg::REG_PPD:         cfg_next.pulses_per_detent = cfg_data[ksc_pkg::PPD_W-1:0];
                ksc_pkg::REG_VOLT_MIN:    cfg_next.volt_min          = cfg_data[ksc_pkg::VAL_W-1:0];
                ksc_pkg::REG_VOLT_MAX:    cfg_next.volt_max          = cfg_data[ksc_pkg::VAL_W-1:0];
                ksc_pkg::REG_CURR_MAX:    cfg_next.curr_max          = cfg_data[ksc_pkg::VAL_W-1:0];
                ksc_pkg::REG_VOLT_FINE:   cfg_next.volt_fine_step    = cfg_data[ksc_pkg::STEP_W-1:0];
                ksc_pkg::REG_VOLT_COARSE: cfg_next.volt_coarse_step  = cfg_data[ksc_pkg::STEP_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                    <= ksc_pkg::CFG_RESET;
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            st_reg.phase               <= ksc_pkg::PH_IDLE;
            st_reg.press_start         <= '0;
            st_reg.adjust_current      <= 1'b0;
            st_reg.coarse_step         <= 1'b0;
            st_reg.volt_value          <= ksc_pkg::VOLT_RESET;
            st_reg.curr_value          <= ksc_pkg::CURR_RESET;
            last_count_reg             <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (adv)
            begin
                st_reg         <= st_next;
                last_count_reg <= last_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            now_reg   <= s_axis_tdata[ksc_pkg::NOW_W-1:0];
            level_reg <= s_axis_tdata[ksc_pkg::NOW_W];
            count_reg <= s_axis_tdata[ksc_pkg::NOW_W+ksc_pkg::CNT_IN_W:ksc_pkg::NOW_W+1];
        end
        if (adv)
        begin
            out_reg <= res_next;
        end
    end

    a_no_detent_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_next.direction == ksc_pkg::DIR_NONE)
        |=> ($stable(st_reg.volt_value) && $stable(st_reg.curr_value)))
        else $error("setpoint moved without a detent");

    a_event_from_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_next.button_event != ksc_pkg::EV_NONE) |-> (st_reg.phase == ksc_pkg::PH_TIMING))
        else $error("button event outside press timing");

    a_volt_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_next.setpoint_changed && !res_next.current_mode)
        |=> (st_reg.volt_value <= $past(cfg_reg.volt_max)))
        else $error("voltage setpoint above maximum");

    a_curr_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_next.setpoint_changed && res_next.current_mode)
        |=> (st_reg.curr_value <= $past(cfg_reg.curr_max)))
        else $error("current setpoint above maximum");

endmodule
